>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks (same-cycle and next-cycle) on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that expr holds at every clock edge out of reset
`define RSL_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// check that cons holds in the cycle after ante
`define RSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg
// Types, constants and the square root step function of the spotlight block.
// ----------------------------------------------------------------------------
package rsl_pkg;

    localparam int CFG_BITS     = 14;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_COL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_ROW = 1'b1;

    localparam int D2_BITS   = 16;
    localparam int ROOT_BITS = 16;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int FAC_BITS  = 17;

    localparam int SQ_STAGES = 4;
    localparam int SQ_STEPS  = ROOT_BITS / SQ_STAGES;

    localparam logic [7:0]           AXIS_CAP    = 8'd160;
    localparam logic [D2_BITS:0]     D2_CAP      = 17'd25600;
    localparam logic [FAC_BITS-1:0]  FACTOR_CAP  = 17'd13107;
    localparam logic [FAC_BITS-1:0]  FACTOR_ONE  = 17'd65536;
    localparam logic [20:0]          NUM_BASE    = 21'd1638400;
    localparam logic [21:0]          RECIP_25    = 22'd2684355;
    localparam int                   RECIP_SHIFT = 26;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        logic [RAD_BITS-1:0]  rad;
    } sq_t;

    function automatic sq_t sqrt_steps(sq_t s);
        sq_t                 r;
        logic [REM_BITS-1:0] rs;
        logic [REM_BITS-1:0] tr;
        r = s;
        for (int i = 0; i < SQ_STEPS; i++) begin
            rs = {r.rem[REM_BITS-3:0], r.rad[RAD_BITS-1 -: 2]};
            tr = {1'b0, r.root, 2'b01};
            if (rs >= tr) begin
                r.rem  = rs - tr;
                r.root = {r.root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r.rem  = rs;
                r.root = {r.root[ROOT_BITS-2:0], 1'b0};
            end
            r.rad = {r.rad[RAD_BITS-3:0], 2'b00};
        end
        return r;
    endfunction

endpackage

>>> hdl/rsl_isqrt.sv
// ----------------------------------------------------------------------------
// rsl_isqrt
// Pipelined integer square root of d2 * 65536, four result bits per stage.
// ----------------------------------------------------------------------------
module rsl_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [rsl_pkg::D2_BITS-1:0]    d2,
    output logic [rsl_pkg::ROOT_BITS-1:0]  root
);
    import rsl_pkg::*;

    sq_t st_reg [SQ_STAGES];
    sq_t st_init;

    assign st_init.rem  = '0;
    assign st_init.root = '0;
    assign st_init.rad  = {d2, {(RAD_BITS-D2_BITS){1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sqrt_steps(st_init);
            for (int i = 1; i < SQ_STAGES; i++) begin
                st_reg[i] <= sqrt_steps(st_reg[i-1]);
            end
        end
    end

    assign root = st_reg[SQ_STAGES-1].root;

endmodule

>>> hdl/radial_spotlight_luma.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luma
// Radial vignette: dims each pixel's luma linearly with distance from a center.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ stream (column, row, luma packed in s_tdata) and
//   dimmed luma leaves on the m_ stream, one result per request, in order.
//   The center is to be set through cfg_wr_en / cfg_index / cfg_wdata
//   while idle; the block itself does not enforce this. Throughput is
//   one pixel per clock while the output is not stalled. There are nine
//   register stages: difference, square, four square root stages,
//   reciprocal scale, product, output register. m_tvalid rises when the
//   request reaches the output register. Reset clears all valid bits and
//   sets the center to zero. When m_tready is low, a valid output register
//   holds and one skid entry catches the pixel leaving the pipeline; the
//   pipeline then freezes and s_tready drops until the skid entry drains.
//   s_tready comes from a register only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radial_spotlight_luma #(
    parameter int  COORD_BITS = 12,
    parameter int  LUMA_BITS  = 16,
    localparam int IN_W       = ((2 * COORD_BITS + LUMA_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((LUMA_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rsl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rsl_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_col, pixel_row, luma_in
    input  logic [IN_W-1:0]                   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // luma_out
    output logic [OUT_W-1:0]                  m_tdata
);
    import rsl_pkg::*;

    localparam int DIFF_W = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam int ABS_W  = DIFF_W - 1;
    localparam int PROD_W = LUMA_BITS + FAC_BITS;

    logic signed [CFG_BITS-1:0] center_col_reg;
    logic signed [CFG_BITS-1:0] center_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_col_reg <= '0;
            center_row_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_COL: center_col_reg <= cfg_wdata;
                REG_CENTER_ROW: center_row_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;
    logic take;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [LUMA_BITS-1:0]  luma_in;

    assign pixel_col = s_tdata[COORD_BITS-1:0];
    assign pixel_row = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign luma_in   = s_tdata[2*COORD_BITS+LUMA_BITS-1:2*COORD_BITS];

    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] neg_x;
    logic signed [DIFF_W-1:0] neg_y;
    logic [ABS_W-1:0]         dx_next;
    logic [ABS_W-1:0]         dy_next;

    assign diff_x  = signed'(DIFF_W'(pixel_col)) - DIFF_W'(center_col_reg);
    assign diff_y  = signed'(DIFF_W'(pixel_row)) - DIFF_W'(center_row_reg);
    assign neg_x   = -diff_x;
    assign neg_y   = -diff_y;
    assign dx_next = diff_x[DIFF_W-1] ? neg_x[ABS_W-1:0] : diff_x[ABS_W-1:0];
    assign dy_next = diff_y[DIFF_W-1] ? neg_y[ABS_W-1:0] : diff_y[ABS_W-1:0];

    logic                 s1_valid_reg;
    logic [ABS_W-1:0]     dx_reg;
    logic [ABS_W-1:0]     dy_reg;
    logic [LUMA_BITS-1:0] s1_luma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            s1_luma_reg <= luma_in;
        end
    end

    logic [D2_BITS-1:0] sq_x;
    logic [D2_BITS-1:0] sq_y;
    logic [D2_BITS:0]   d2_sum;
    logic               cap_next;

    assign sq_x     = D2_BITS'(dx_reg[7:0]) * D2_BITS'(dx_reg[7:0]);
    assign sq_y     = D2_BITS'(dy_reg[7:0]) * D2_BITS'(dy_reg[7:0]);
    assign d2_sum   = (D2_BITS+1)'(sq_x) + (D2_BITS+1)'(sq_y);
    assign cap_next = (dx_reg >= ABS_W'(AXIS_CAP)) || (dy_reg >= ABS_W'(AXIS_CAP))
                      || (d2_sum >= D2_CAP);

    logic                 s2_valid_reg;
    logic [D2_BITS-1:0]   d2_reg;
    logic                 s2_cap_reg;
    logic [LUMA_BITS-1:0] s2_luma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg      <= d2_sum[D2_BITS-1:0];
            s2_cap_reg  <= cap_next;
            s2_luma_reg <= s1_luma_reg;
        end
    end

    logic [ROOT_BITS-1:0] root;

    rsl_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .d2   (d2_reg),
        .root (root)
    );

    logic                 dly_valid_reg [SQ_STAGES];
    logic                 dly_cap_reg   [SQ_STAGES];
    logic [LUMA_BITS-1:0] dly_luma_reg  [SQ_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_STAGES; i++) begin
                dly_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            dly_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < SQ_STAGES; i++) begin
                dly_valid_reg[i] <= dly_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_cap_reg[0]  <= s2_cap_reg;
            dly_luma_reg[0] <= s2_luma_reg;
            for (int i = 1; i < SQ_STAGES; i++) begin
                dly_cap_reg[i]  <= dly_cap_reg[i-1];
                dly_luma_reg[i] <= dly_luma_reg[i-1];
            end
        end
    end

    logic [20:0]          num;
    logic [42:0]          quot_prod;
    logic [FAC_BITS-1:0]  fac_next;

    assign num       = NUM_BASE - {root, 5'b00000};
    assign quot_prod = 43'(num) * 43'(RECIP_25);
    assign fac_next  = dly_cap_reg[SQ_STAGES-1] ? FACTOR_CAP
                       : quot_prod[RECIP_SHIFT+FAC_BITS-1:RECIP_SHIFT];

    logic                 fac_valid_reg;
    logic [FAC_BITS-1:0]  fac_reg;
    logic [LUMA_BITS-1:0] fac_luma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fac_valid_reg <= 1'b0;
        end else if (en) begin
            fac_valid_reg <= dly_valid_reg[SQ_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fac_reg      <= fac_next;
            fac_luma_reg <= dly_luma_reg[SQ_STAGES-1];
        end
    end

    logic [PROD_W-1:0] luma_prod;

    assign luma_prod = PROD_W'(fac_luma_reg) * PROD_W'(fac_reg);

    logic                 lst_valid_reg;
    logic [LUMA_BITS-1:0] lst_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lst_valid_reg <= 1'b0;
        end else if (en) begin
            lst_valid_reg <= fac_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lst_data_reg <= luma_prod[LUMA_BITS+15:16];
        end
    end

    logic                 out_ready;
    logic [LUMA_BITS-1:0] out_data_reg;
    logic [LUMA_BITS-1:0] skid_data_reg;

    assign take      = en && lst_valid_reg;
    assign out_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : lst_data_reg;
        end else if (take) begin
            skid_data_reg <= lst_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    `RSL_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full, output empty")
    `RSL_ASSERT_NEXT(a_stall_to_skid, !out_ready && take, skid_valid_reg, "request lost on stall")
    `RSL_ASSERT(a_factor_range, fac_valid_reg |-> (fac_reg <= FACTOR_ONE), "factor above one")

endmodule
